// ===== sv/thm_pkg.sv =====
// shared types and constants for the thermostat block
`timescale 1ns / 1ps

package thm_pkg;

    localparam int OP_W       = 2;
    localparam int KEY_W      = 2;
    localparam int RAW_W      = 16;
    localparam int TICK_W     = 8;
    localparam int SEC_W      = 6;
    localparam int MIN_W      = 6;
    localparam int HOUR_W     = 5;
    localparam int SETP_W     = 7;
    localparam int MODE_W     = 2;
    localparam int WHOLE_W    = 8;
    localparam int FRAC_W     = 4;

    localparam logic [TICK_W-1:0] TPS_RESET   = 8'd20;
    localparam logic [SEC_W-1:0]  SEC_LIMIT   = 6'd60;
    localparam logic [MIN_W-1:0]  MIN_LIMIT   = 6'd60;
    localparam logic [HOUR_W-1:0] HOUR_LIMIT  = 5'd24;
    localparam logic [HOUR_W-1:0] HOUR_MAX    = 5'd23;
    localparam logic [HOUR_W-1:0] HOUR_RESET  = 5'd12;
    localparam logic [MIN_W-1:0]  MIN_MAX     = 6'd59;
    localparam logic [SETP_W-1:0] SETP_MAX    = 7'd99;
    localparam logic [SETP_W-1:0] SETP_MIN    = 7'd1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_KEY    = 2'd1,
        OP_SAMPLE = 2'd2
    } t_op;

    typedef enum logic [KEY_W-1:0] {
        KEY_MODE   = 2'd0,
        KEY_INC    = 2'd1,
        KEY_DEC    = 2'd2,
        KEY_TOGGLE = 2'd3
    } t_key;

    typedef enum logic [MODE_W-1:0] {
        MODE_NORMAL = 2'd0,
        MODE_HOURS  = 2'd1,
        MODE_MINS   = 2'd2,
        MODE_SETP   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key_code;
        logic [RAW_W-1:0] sample_raw;
    } t_item;

endpackage

// ===== sv/thm_if.sv =====
// channel interfaces: input items, status results, configuration writes
`timescale 1ns / 1ps

interface thm_item_if import thm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key_code;
    logic [RAW_W-1:0] sample_raw;

    modport source (output valid, op, key_code, sample_raw, input ready);
    modport sink   (input valid, op, key_code, sample_raw, output ready);
endinterface

interface thm_stat_if import thm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [HOUR_W-1:0]  hours;
    logic [MIN_W-1:0]   minutes;
    logic [SEC_W-1:0]   seconds;
    logic [SETP_W-1:0]  setpoint;
    logic [MODE_W-1:0]  adjust_mode;
    logic               control_enabled;
    logic               drive_active;
    logic [WHOLE_W-1:0] temp_whole;
    logic [FRAC_W-1:0]  temp_fraction;

    modport source (output valid, hours, minutes, seconds, setpoint, adjust_mode,
                    control_enabled, drive_active, temp_whole, temp_fraction,
                    input ready);
    modport sink   (input valid, hours, minutes, seconds, setpoint, adjust_mode,
                    control_enabled, drive_active, temp_whole, temp_fraction,
                    output ready);
endinterface

interface thm_cfg_if import thm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== sv/thm_in_reg.sv =====
// input register stage for item beats
`timescale 1ns / 1ps

module thm_in_reg import thm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    thm_item_if.sink        i_item,
    input  logic            i_take,
    output logic            o_valid,
    output t_item           o_item
);

    logic  r_valid;
    t_item r_item;

    // stage frees up when empty or when the core takes the held beat
    assign i_item.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_item <= '{op: i_item.op, key_code: i_item.key_code,
                        sample_raw: i_item.sample_raw};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== sv/thm_core.sv =====
// clock, key and thermostat state update with registered status output
`timescale 1ns / 1ps

module thm_core import thm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_item      i_item,
    output logic       o_take,
    thm_cfg_if.sink    i_cfg,
    thm_stat_if.source o_status
);

    logic [TICK_W-1:0]  r_tps;
    logic [TICK_W-1:0]  r_tick,  n_tick;
    logic [SEC_W-1:0]   r_sec,   n_sec;
    logic [MIN_W-1:0]   r_min,   n_min;
    logic [HOUR_W-1:0]  r_hour,  n_hour;
    logic [SETP_W-1:0]  r_setp,  n_setp;
    logic [MODE_W-1:0]  r_mode,  n_mode;
    logic               r_enable, n_enable;
    logic               r_drive,  n_drive;
    logic [WHOLE_W-1:0] r_whole, n_whole;
    logic [FRAC_W-1:0]  r_frac,  n_frac;
    logic               r_out_valid;

    logic [TICK_W-1:0]  tick_inc;
    logic [SEC_W-1:0]   sec_a;
    logic [MIN_W-1:0]   min_a;
    logic [HOUR_W-1:0]  hour_a;

    assign i_cfg.ready = 1'b1;
    assign o_take = i_valid && (!r_out_valid || o_status.ready);

    always_comb begin
        n_tick   = r_tick;
        n_sec    = r_sec;
        n_min    = r_min;
        n_hour   = r_hour;
        n_setp   = r_setp;
        n_mode   = r_mode;
        n_enable = r_enable;
        n_whole  = r_whole;
        n_frac   = r_frac;
        n_drive  = r_drive;
        tick_inc = r_tick + 1'b1;
        sec_a    = r_sec;
        min_a    = r_min;
        hour_a   = r_hour;

        case (t_op'(i_item.op))
            OP_TICK: begin
                // tick, second, minute and hour carry in one pass
                n_tick = tick_inc;
                if (tick_inc >= r_tps) begin
                    sec_a  = r_sec + 1'b1;
                    n_tick = '0;
                end
                n_sec = sec_a;
                if (sec_a >= SEC_LIMIT) begin
                    min_a = r_min + 1'b1;
                    n_sec = '0;
                end
                n_min = min_a;
                if (min_a >= MIN_LIMIT) begin
                    hour_a = r_hour + 1'b1;
                    n_min  = '0;
                end
                n_hour = (hour_a >= HOUR_LIMIT) ? '0 : hour_a;
            end
            OP_KEY: begin
                case (t_key'(i_item.key_code))
                    KEY_MODE: begin
                        n_mode = r_mode + 1'b1;
                    end
                    KEY_INC: begin
                        case (t_mode'(r_mode))
                            MODE_HOURS: n_hour = (r_hour >= HOUR_MAX - 1'b1) ?
                                                 HOUR_MAX : r_hour + 1'b1;
                            MODE_MINS:  n_min  = (r_min >= MIN_MAX - 1'b1) ?
                                                 MIN_MAX : r_min + 1'b1;
                            MODE_SETP:  n_setp = (r_setp >= SETP_MAX - 1'b1) ?
                                                 SETP_MAX : r_setp + 1'b1;
                            default: ;
                        endcase
                    end
                    KEY_DEC: begin
                        case (t_mode'(r_mode))
                            MODE_HOURS: n_hour = (r_hour == '0) ? '0 : r_hour - 1'b1;
                            MODE_MINS:  n_min  = (r_min == '0) ? '0 : r_min - 1'b1;
                            // setpoint floor is one, zero also lands there
                            MODE_SETP:  n_setp = (r_setp <= SETP_MIN + 1'b1) ?
                                                 SETP_MIN : r_setp - 1'b1;
                            default: ;
                        endcase
                    end
                    KEY_TOGGLE: begin
                        n_enable = !r_enable;
                    end
                    default: ;
                endcase
            end
            OP_SAMPLE: begin
                n_whole = i_item.sample_raw[FRAC_W +: WHOLE_W];
                n_frac  = i_item.sample_raw[FRAC_W-1:0];
            end
            default: ;
        endcase

        // hysteresis: off while disabled, else on above setpoint, off below, hold when equal
        if (!n_enable) begin
            n_drive = 1'b0;
        end else if (n_whole > {1'b0, n_setp}) begin
            n_drive = 1'b1;
        end else if (n_whole < {1'b0, n_setp}) begin
            n_drive = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps       <= TPS_RESET;
            r_tick      <= '0;
            r_sec       <= '0;
            r_min       <= '0;
            r_hour      <= HOUR_RESET;
            r_setp      <= '0;
            r_mode      <= MODE_NORMAL;
            r_enable    <= 1'b0;
            r_drive     <= 1'b0;
            r_whole     <= '0;
            r_frac      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_tps <= i_cfg.data;
            end
            if (o_take) begin
                r_tick      <= n_tick;
                r_sec       <= n_sec;
                r_min       <= n_min;
                r_hour      <= n_hour;
                r_setp      <= n_setp;
                r_mode      <= n_mode;
                r_enable    <= n_enable;
                r_drive     <= n_drive;
                r_whole     <= n_whole;
                r_frac      <= n_frac;
                r_out_valid <= 1'b1;
            end else if (o_status.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // state registers double as the result register: they only move on a take
    assign o_status.valid           = r_out_valid;
    assign o_status.hours           = r_hour;
    assign o_status.minutes         = r_min;
    assign o_status.seconds         = r_sec;
    assign o_status.setpoint        = r_setp;
    assign o_status.adjust_mode     = r_mode;
    assign o_status.control_enabled = r_enable;
    assign o_status.drive_active    = r_drive;
    assign o_status.temp_whole      = r_whole;
    assign o_status.temp_fraction   = r_frac;

    a_clock_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hour < HOUR_LIMIT) && (r_min < MIN_LIMIT) && (r_sec < SEC_LIMIT))
        else $error("clock count out of range");

    a_setp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_setp <= SETP_MAX)
        else $error("setpoint above maximum");

    a_drive_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drive |-> r_enable)
        else $error("drive on while control disabled");

    a_state_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_take |=> $stable(r_hour) && $stable(r_min) && $stable(r_setp)
                    && $stable(r_drive))
        else $error("state moved without a beat");

    a_result_from_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_valid))
        else $error("result without an input beat");

endmodule

// ===== sv/thermostat_with_clock_and_keys.sv =====
// top level of the thermostat with time-of-day clock and key handling
`timescale 1ns / 1ps

// On/off thermostat with a time-of-day clock. Each input beat is a tick, a
// key event or a temperature sample, and each yields exactly one status beat.
// An item goes through an input register and the update logic into the
// state registers, which also form the result register; one item is taken
// every cycle while the status sink keeps up. ticks_per_second is written
// through the configuration channel, which is always ready; write it only
// while idle. After reset the clock reads 12:00:00 with control disabled.

module thermostat_with_clock_and_keys import thm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    thm_item_if.sink   i_item,
    thm_cfg_if.sink    i_cfg,
    thm_stat_if.source o_status
);

    logic  stage_valid;
    logic  stage_take;
    t_item stage_item;

    thm_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_take  (stage_take),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    thm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_valid),
        .i_item   (stage_item),
        .o_take   (stage_take),
        .i_cfg    (i_cfg),
        .o_status (o_status)
    );

endmodule
